[sv/mpsp_pkg.sv]
package mpsp_pkg;

   localparam int LOG_IN_WIDTH = 32;
   localparam int LIMIT_WIDTH = 17;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [1:0] REG_GRID_COLS = 2'd1;
   localparam logic [1:0] REG_KMER_HALF = 2'd2;

   typedef struct packed {
      logic                    req_type;
      logic [LOG_IN_WIDTH-1:0] log_match;
      logic [LOG_IN_WIDTH-1:0] log_extend;
   } item_type;

   typedef struct packed {
      logic [10:0] grid_rows;
      logic [8:0]  grid_cols;
      logic [2:0]  kmer_half;
   } cfg_type;

endpackage

[sv/mpsp_front.sv]
module mpsp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mpsp_pkg::item_type req_item,
   output logic               q_valid,
   output mpsp_pkg::item_type q_item,
   input  logic               q_pop
);

   mpsp_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

[sv/mpsp_back.sv]
module mpsp_back #(
   parameter int MAX_ROWS  = 1024,
   parameter int MAX_COLS  = 256,
   parameter int LOG_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  mpsp_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  mpsp_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_border_valid,
   output logic [8:0]         rsp_kmer_position,
   output logic [9:0]         rsp_time_index,
   output logic               rsp_last_border
);

   localparam int LW = LOG_WIDTH;
   localparam int RB = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int CB = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
   localparam int XW = (RB > CB) ? RB : CB;
   localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
   localparam int EW = ((LW > mpsp_pkg::LOG_IN_WIDTH) ? LW : mpsp_pkg::LOG_IN_WIDTH) + 1;
   localparam int PW = CB + 4;
   localparam int LIM = mpsp_pkg::LIMIT_WIDTH;
   localparam logic signed [LW-1:0] LNEG = {1'b1, {(LW-1){1'b0}}};
   localparam logic signed [LW-1:0] LMAX = ~LNEG;
   localparam logic signed [EW-1:0] LMAX_E = (EW'(1) <<< (LW - 1)) - EW'(1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LD_RD, ST_LD_ADD, ST_LD_CMP, ST_TB_RD, ST_TB_EV, ST_RD_MEM, ST_RD_OUT
   } state_type;

   function automatic logic signed [LW-1:0] take_log(input logic [31:0] raw);
      logic signed [EW-1:0] s;
      s = {{(EW-32){raw[31]}}, raw};
      if (raw == 32'h8000_0000) begin
         return LNEG;
      end
      if (s > LMAX_E) begin
         return LMAX;
      end
      if (s < -LMAX_E) begin
         return LNEG + LW'(1);
      end
      return LW'(s);
   endfunction

   function automatic logic signed [LW-1:0] sat_add(input logic signed [LW-1:0] a,
                                                    input logic signed [LW-1:0] b);
      logic [LW:0] s;
      s = {a[LW-1], a} + {b[LW-1], b};
      if (a == LNEG || b == LNEG) begin
         return LNEG;
      end
      if (s[LW] != s[LW-1]) begin
         return s[LW] ? LNEG + LW'(1) : LMAX;
      end
      if (s[LW-1:0] == LNEG) begin
         return LNEG + LW'(1);
      end
      return s[LW-1:0];
   endfunction

   state_type state_ff;
   logic [RB-1:0] row_ff, tb_t_ff;
   logic [CB-1:0] col_ff, tb_n_ff;
   logic          in_match_ff;
   logic [CB:0]   cnt_ff;
   logic          rd_zero_ff, rd_last_ff;
   logic          rv_ff;
   logic          vld_ff [MAX_COLS];
   logic signed [LW-1:0] lm_ff, le_ff, diag_ff;
   logic signed [LW-1:0] diag_m_ff, from_m_ff, from_e_ff, old_e_ff;
   logic signed [LW-1:0] mq_ff, eq_ff;
   logic [2:0]    dq_ff;
   logic [RB+CB-1:0] sq_ff;
   logic          rsp_valid_ff, rsp_bv_ff, rsp_last_ff;
   logic [8:0]    rsp_kp_ff;
   logic [9:0]    rsp_ti_ff;

   logic signed [LW-1:0] mrow [MAX_COLS];
   logic signed [LW-1:0] erow [MAX_COLS];
   logic [2:0]           dmem [MAX_ROWS * MAX_COLS];
   logic [RB+CB-1:0]     stack [MAX_COLS];

   logic signed [LW-1:0] old_m, old_e, m_v, e_v, best;
   logic [2:0]    dec;
   logic          live;
   logic [LIM-1:0] rows_m1, cols_m1;
   logic          push;
   logic [AW-1:0] wr_addr, tb_addr;
   logic          out_free;

   always_comb begin
      if (cfg.grid_rows < 11'd2) begin
         rows_m1 = LIM'(1);
      end else if (LIM'(cfg.grid_rows) > LIM'(MAX_ROWS)) begin
         rows_m1 = LIM'(MAX_ROWS - 1);
      end else begin
         rows_m1 = LIM'(cfg.grid_rows) - LIM'(1);
      end
      if (cfg.grid_cols < 9'd2) begin
         cols_m1 = LIM'(1);
      end else if (LIM'(cfg.grid_cols) > LIM'(MAX_COLS)) begin
         cols_m1 = LIM'(MAX_COLS - 1);
      end else begin
         cols_m1 = LIM'(cfg.grid_cols) - LIM'(1);
      end
   end

   always_comb begin
      old_m = rv_ff ? mq_ff : LNEG;
      old_e = rv_ff ? eq_ff : ((col_ff == '0) ? '0 : LNEG);
      live  = (col_ff != '0) && (XW'(col_ff) <= XW'(row_ff));
      best  = (from_m_ff > from_e_ff) ? from_m_ff : from_e_ff;
      m_v   = live ? diag_m_ff : LNEG;
      e_v   = live ? best : LNEG;
      if (col_ff == '0 || row_ff == '0) begin
         dec = 3'b000;
      end else begin
         dec = {e_v == from_e_ff, e_v == from_m_ff, m_v == diag_m_ff};
      end
      wr_addr  = AW'(row_ff) * AW'(MAX_COLS) + AW'(col_ff);
      tb_addr  = AW'(tb_t_ff) * AW'(MAX_COLS) + AW'(tb_n_ff);
      push     = (state_ff == ST_TB_EV) && (tb_t_ff != '0) && (tb_n_ff != '0) && in_match_ff
                 && dq_ff[0] && (cnt_ff < (CB+1)'(MAX_COLS));
      out_free = !rsp_valid_ff || rsp_ready;
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         diag_ff      <= LNEG;
         rsp_valid_ff <= 1'b0;
         in_match_ff  <= 1'b0;
         for (int i = 0; i < MAX_COLS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_RD_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.req_type == mpsp_pkg::REQ_READ) begin
                     if (cnt_ff == '0) begin
                        rd_zero_ff <= 1'b1;
                        state_ff   <= ST_RD_OUT;
                     end else begin
                        rd_zero_ff <= 1'b0;
                        rd_last_ff <= (cnt_ff == (CB+1)'(1));
                        cnt_ff     <= cnt_ff - (CB+1)'(1);
                        state_ff   <= ST_RD_MEM;
                     end
                  end else begin
                     lm_ff <= take_log(q_item.log_match);
                     le_ff <= take_log(q_item.log_extend);
                     if (row_ff == '0 && col_ff == '0) begin
                        diag_ff <= LNEG;
                        cnt_ff  <= '0;
                        for (int i = 0; i < MAX_COLS; i++) begin
                           vld_ff[i] <= 1'b0;
                        end
                     end
                     state_ff <= ST_LD_RD;
                  end
               end
            end
            ST_LD_RD: begin
               rv_ff    <= vld_ff[col_ff];
               state_ff <= ST_LD_ADD;
            end
            ST_LD_ADD: begin
               diag_m_ff <= sat_add(diag_ff, lm_ff);
               from_m_ff <= sat_add(old_m, le_ff);
               from_e_ff <= sat_add(old_e, le_ff);
               old_e_ff  <= old_e;
               state_ff  <= ST_LD_CMP;
            end
            ST_LD_CMP: begin
               if (row_ff != '0) begin
                  diag_ff        <= old_e_ff;
                  vld_ff[col_ff] <= 1'b1;
               end
               if (LIM'(col_ff) >= cols_m1) begin
                  col_ff <= '0;
                  if (LIM'(row_ff) >= rows_m1) begin
                     tb_t_ff     <= row_ff;
                     tb_n_ff     <= col_ff;
                     in_match_ff <= 1'b0;
                     row_ff      <= '0;
                     state_ff    <= ST_TB_RD;
                  end else begin
                     row_ff   <= row_ff + RB'(1);
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  col_ff   <= col_ff + CB'(1);
                  state_ff <= ST_IDLE;
               end
            end
            ST_TB_RD: begin
               state_ff <= ST_TB_EV;
            end
            ST_TB_EV: begin
               if (tb_t_ff == '0 || tb_n_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else if (in_match_ff) begin
                  if (dq_ff[0]) begin
                     if (push) begin
                        cnt_ff <= cnt_ff + (CB+1)'(1);
                     end
                     tb_t_ff     <= tb_t_ff - RB'(1);
                     tb_n_ff     <= tb_n_ff - CB'(1);
                     in_match_ff <= 1'b0;
                     state_ff    <= ST_TB_RD;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else if (dq_ff[1]) begin
                  tb_t_ff     <= tb_t_ff - RB'(1);
                  in_match_ff <= 1'b1;
                  state_ff    <= ST_TB_RD;
               end else if (dq_ff[2]) begin
                  tb_t_ff  <= tb_t_ff - RB'(1);
                  state_ff <= ST_TB_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD_MEM: begin
               state_ff <= ST_RD_OUT;
            end
            ST_RD_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (rd_zero_ff) begin
                     rsp_bv_ff   <= 1'b0;
                     rsp_kp_ff   <= '0;
                     rsp_ti_ff   <= '0;
                     rsp_last_ff <= 1'b0;
                  end else begin
                     rsp_bv_ff   <= 1'b1;
                     rsp_kp_ff   <= 9'(PW'(sq_ff[CB-1:0]) + PW'(cfg.kmer_half));
                     rsp_ti_ff   <= 10'(sq_ff[RB+CB-1:CB]);
                     rsp_last_ff <= rd_last_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LD_RD) begin
         mq_ff <= mrow[col_ff];
         eq_ff <= erow[col_ff];
      end
      if (state_ff == ST_LD_CMP) begin
         dmem[wr_addr] <= dec;
         if (row_ff != '0) begin
            mrow[col_ff] <= m_v;
            erow[col_ff] <= e_v;
         end
      end
      if (state_ff == ST_TB_RD) begin
         dq_ff <= dmem[tb_addr];
      end
      if (push) begin
         stack[cnt_ff[CB-1:0]] <= {tb_t_ff - RB'(1), tb_n_ff - CB'(1)};
      end
      if (state_ff == ST_RD_MEM) begin
         sq_ff <= stack[cnt_ff[CB-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_border_valid  = rsp_bv_ff;
   assign rsp_kmer_position = rsp_kp_ff;
   assign rsp_time_index    = rsp_ti_ff;
   assign rsp_last_border   = rsp_last_ff;

endmodule

[sv/max_posterior_segment_path.sv]
// Two-state segmentation path finder. Items arrive on the req_ channel: a load item
// (req_type 0) carries the match and extend log probabilities of the next grid cell in
// row-major order, a read item (req_type 1) asks for the next segment border.
// Only read items produce a result item on the rsp_ channel.
// Grid size and the k-mer offset are set through the csr_ write port, by the user
// only while idle; the block does not enforce it. A two-entry queue sits in front of
// the cell engine, so req_ready drops only when the queue is full. A load item passes
// the row buffer read, the saturating add stage and the compare and write-back stage.
// After the last cell, the traceback walks the decision memory, a read and an evaluate
// state per step, before the next item is taken. A read item passes the stack read
// state, skipped when the border count is zero, and then the output state.
// A stalled receiver holds the result in the output register; the engine stops
// only when a second result is ready, and the queue keeps accepting until full.
// Reset is synchronous and clears the counters, the border count and the output valid
// flag; the row buffers are marked empty per column, and no clearing pass is needed.
module max_posterior_segment_path #(
   parameter int MAX_ROWS  = 1024,
   parameter int MAX_COLS  = 256,
   parameter int LOG_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_log_match,
   input  logic [31:0] req_log_extend,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_border_valid,
   output logic [8:0]  rsp_kmer_position,
   output logic [9:0]  rsp_time_index,
   output logic        rsp_last_border,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   mpsp_pkg::cfg_type  cfg_ff;
   mpsp_pkg::item_type req_item;
   mpsp_pkg::item_type q_item;
   logic               q_valid;
   logic               q_pop;

   assign req_item = '{req_type: req_type, log_match: req_log_match,
                       log_extend: req_log_extend};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows <= 11'd2;
         cfg_ff.grid_cols <= 9'd2;
         cfg_ff.kmer_half <= 3'd2;
      end else if (csr_we) begin
         case (csr_index)
            mpsp_pkg::REG_GRID_ROWS: cfg_ff.grid_rows <= csr_wdata;
            mpsp_pkg::REG_GRID_COLS: cfg_ff.grid_cols <= csr_wdata[8:0];
            mpsp_pkg::REG_KMER_HALF: cfg_ff.kmer_half <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   mpsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   mpsp_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .LOG_WIDTH(LOG_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_border_valid (rsp_border_valid),
      .rsp_kmer_position(rsp_kmer_position),
      .rsp_time_index   (rsp_time_index),
      .rsp_last_border  (rsp_last_border)
   );

endmodule

[sv/mpsp_checker.sv]
module mpsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_border_valid,
   input logic [8:0] rsp_kmer_position,
   input logic [9:0] rsp_time_index,
   input logic       rsp_last_border
);

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kmer_position)
                                  && $stable(rsp_time_index))
      else $error("result item changed while stalled");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_border_valid |-> rsp_kmer_position == 9'd0
                                         && rsp_time_index == 10'd0 && !rsp_last_border)
      else $error("empty result item carries data");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_border |-> rsp_border_valid)
      else $error("last border flagged on an empty result item");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result item shown right after reset");

endmodule

bind max_posterior_segment_path mpsp_checker u_mpsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_border_valid (rsp_border_valid),
   .rsp_kmer_position(rsp_kmer_position),
   .rsp_time_index   (rsp_time_index),
   .rsp_last_border  (rsp_last_border)
);
